// ===== rtl/clpr_pkg.sv =====
`timescale 1ns / 1ps

package clpr_pkg;

    // Current measurement and boost limit constants
    localparam logic [15:0] CURRENT_CAP_Q8 = 16'd64000;
    localparam logic [5:0]  BOOST_BASE     = 6'd15;
    localparam logic [4:0]  BOOST_SPAN     = 5'd20;
    localparam logic [5:0]  BOOST_FULL     = 6'd55;
    localparam logic [10:0] POT_FULL_SCALE = 11'd1023;
    localparam logic [11:0] SENSOR_OFFSET  = 12'd2;

    // Configuration reset values
    localparam logic [15:0] RST_RPM_THRESHOLD    = 16'd335;
    localparam logic [7:0]  RST_LOW_LIMIT        = 8'd15;
    localparam logic [7:0]  RST_HIGH_LIMIT       = 8'd48;
    localparam logic [7:0]  RST_DUTY_MAX         = 8'd255;
    localparam logic [7:0]  RST_DUTY_MIN         = 8'd45;
    localparam logic [7:0]  RST_AUTO_START_DUTY  = 8'd85;
    localparam logic [7:0]  RST_BOOST_START_DUTY = 8'd104;
    localparam logic [7:0]  RST_AMPS_PER_BIT_Q8  = 8'd79;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPM_THRESHOLD    = 3'd0,
        CFG_LOW_LIMIT        = 3'd1,
        CFG_HIGH_LIMIT       = 3'd2,
        CFG_DUTY_MAX         = 3'd3,
        CFG_DUTY_MIN         = 3'd4,
        CFG_AUTO_START_DUTY  = 3'd5,
        CFG_BOOST_START_DUTY = 3'd6,
        CFG_AMPS_PER_BIT_Q8  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_LOW   = 2'd1,
        MODE_HIGH  = 2'd2,
        MODE_BOOST = 2'd3
    } t_mode;

    typedef struct packed {
        logic [15:0] current_q8;
        logic [5:0]  boost_limit;
    } t_meas;

endpackage

// ===== rtl/clpr_measure.sv =====
`timescale 1ns / 1ps

module clpr_measure (
    input  logic [9:0]       i_current_sample,
    input  logic [9:0]       i_reference_sample,
    input  logic [9:0]       i_pot_sample,
    input  logic [7:0]       i_amps_per_bit_q8,
    output clpr_pkg::t_meas  o_meas
);
    import clpr_pkg::*;

    logic signed [11:0] diff;
    logic               diff_pos;
    logic [18:0]        prod;
    logic [14:0]        pot_x20;
    logic [4:0]         q_est;
    logic [10:0]        rem_est;
    logic [4:0]         q;

    always_comb begin
        diff     = $signed({2'b00, i_current_sample}) - $signed({2'b00, i_reference_sample})
                   - $signed(SENSOR_OFFSET);
        diff_pos = !diff[11] && (diff != 12'sd0);
        prod     = 19'(diff[10:0]) * 19'(i_amps_per_bit_q8);
        if (!diff_pos) begin
            o_meas.current_q8 = '0;
        end else if (prod > 19'(CURRENT_CAP_Q8)) begin
            o_meas.current_q8 = CURRENT_CAP_Q8;
        end else begin
            o_meas.current_q8 = prod[15:0];
        end

        // pot*20/1023: estimate with /1024, remainder is x mod 1024 plus
        // the estimate, one correction covers it
        pot_x20 = {1'b0, i_pot_sample, 4'b0000} + {3'b000, i_pot_sample, 2'b00};
        q_est   = pot_x20[14:10];
        rem_est = {1'b0, pot_x20[9:0]} + {6'b000000, q_est};
        q       = (rem_est >= POT_FULL_SCALE) ? q_est + 5'd1 : q_est;
        if (q == BOOST_SPAN) begin
            o_meas.boost_limit = BOOST_FULL;
        end else begin
            o_meas.boost_limit = BOOST_BASE + {1'b0, q};
        end
    end

endmodule

// ===== rtl/current_limited_pwm_ramp_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       to block   i_in_valid / o_in_stall   i_current_sample .. i_boost_btn
// out      from block o_out_valid / i_out_stall o_pwm_duty .. o_boost_limit
// cfg      to block   i_cfg_we                  i_cfg_index, i_cfg_data
//
// Input register, then measurement and duty ramp in one pass into the result register.
// One item per cycle sustained while the output is not stalled; a taken item moves from the
// input register into the result register, where it is offered as a result.
// Duty state updates as an item moves into the result register, so the next item
// sees it. Reset is synchronous, active low, and empties both stages.
// o_in_stall rises only when both registers hold items and the output is stalled.

module current_limited_pwm_ramp_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [9:0]                          i_current_sample,
    input  logic [9:0]                          i_reference_sample,
    input  logic [9:0]                          i_pot_sample,
    input  logic [15:0]                         i_motor_rpm,
    input  logic                                i_throttle_pin,
    input  logic                                i_boost_btn,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_pwm_duty,
    output logic [15:0]                         o_current_q8,
    output logic [1:0]                          o_drive_mode,
    output logic [5:0]                          o_boost_limit,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [clpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [clpr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import clpr_pkg::*;

    // ---------------- configuration registers ----------------
    logic [15:0] r_rpm_threshold;
    logic [7:0]  r_low_limit;
    logic [7:0]  r_high_limit;
    logic [7:0]  r_duty_max;
    logic [7:0]  r_duty_min;
    logic [7:0]  r_auto_start_duty;
    logic [7:0]  r_boost_start_duty;
    logic [7:0]  r_amps_per_bit_q8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_threshold    <= RST_RPM_THRESHOLD;
            r_low_limit        <= RST_LOW_LIMIT;
            r_high_limit       <= RST_HIGH_LIMIT;
            r_duty_max         <= RST_DUTY_MAX;
            r_duty_min         <= RST_DUTY_MIN;
            r_auto_start_duty  <= RST_AUTO_START_DUTY;
            r_boost_start_duty <= RST_BOOST_START_DUTY;
            r_amps_per_bit_q8  <= RST_AMPS_PER_BIT_Q8;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RPM_THRESHOLD:    r_rpm_threshold    <= i_cfg_data;
                CFG_LOW_LIMIT:        r_low_limit        <= i_cfg_data[7:0];
                CFG_HIGH_LIMIT:       r_high_limit       <= i_cfg_data[7:0];
                CFG_DUTY_MAX:         r_duty_max         <= i_cfg_data[7:0];
                CFG_DUTY_MIN:         r_duty_min         <= i_cfg_data[7:0];
                CFG_AUTO_START_DUTY:  r_auto_start_duty  <= i_cfg_data[7:0];
                CFG_BOOST_START_DUTY: r_boost_start_duty <= i_cfg_data[7:0];
                CFG_AMPS_PER_BIT_Q8:  r_amps_per_bit_q8  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic out_ready;
    logic s1_ready;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign s1_ready    = !r_s1_valid || out_ready;
    assign o_in_stall  = !s1_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready)  r_s1_valid  <= i_in_valid;
            if (out_ready) r_out_valid <= r_s1_valid;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic [9:0]  r_s1_cur;
    logic [9:0]  r_s1_ref;
    logic [9:0]  r_s1_pot;
    logic [15:0] r_s1_rpm;
    logic        r_s1_thr_pin;
    logic        r_s1_bst_pin;

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_cur     <= i_current_sample;
            r_s1_ref     <= i_reference_sample;
            r_s1_pot     <= i_pot_sample;
            r_s1_rpm     <= i_motor_rpm;
            r_s1_thr_pin <= i_throttle_pin;
            r_s1_bst_pin <= i_boost_btn;
        end
    end

    // ---------------- current and boost limit ----------------
    t_meas s1_meas;
    logic  rpm_high;
    logic  thr_dn;
    logic  bst_dn;

    clpr_measure u_measure (
        .i_current_sample   (r_s1_cur),
        .i_reference_sample (r_s1_ref),
        .i_pot_sample       (r_s1_pot),
        .i_amps_per_bit_q8  (r_amps_per_bit_q8),
        .o_meas             (s1_meas)
    );

    assign rpm_high = (r_s1_rpm >= r_rpm_threshold);
    assign thr_dn   = !r_s1_thr_pin;   // buttons are active low
    assign bst_dn   = !r_s1_bst_pin;

    // ---------------- duty ramp and result ----------------
    logic [7:0]  r_duty;
    logic        r_auto_started;
    logic        r_boost_armed;
    logic [7:0]  n_duty;
    logic        n_auto_started;
    logic        n_boost_armed;
    t_mode       n_mode;

    logic [7:0]         limit;
    logic               over_speed;
    logic               over_boost;
    logic               over;
    logic signed [9:0]  d;

    always_comb begin
        limit          = rpm_high ? r_high_limit : r_low_limit;
        over_speed     = s1_meas.current_q8 > {limit, 8'h00};
        over_boost     = s1_meas.current_q8 > {2'b00, s1_meas.boost_limit, 8'h00};
        n_mode         = rpm_high ? MODE_HIGH : MODE_LOW;
        n_auto_started = r_auto_started;
        n_boost_armed  = r_boost_armed;
        d              = $signed({2'b00, r_duty});
        over           = 1'b0;

        if (thr_dn || bst_dn) begin
            // first throttle press loads the preset, unless boost is held or already over limit
            if (!r_auto_started && !bst_dn && !over_speed) begin
                d              = $signed({2'b00, r_auto_start_duty});
                n_auto_started = 1'b1;
            end else if (bst_dn) begin
                n_mode = MODE_BOOST;
                if (r_boost_armed) begin
                    d             = $signed({2'b00, r_boost_start_duty});
                    n_boost_armed = 1'b0;
                end
            end
            over = (n_mode == MODE_BOOST) ? over_boost : over_speed;
            if (over) begin
                d = d - ((n_mode == MODE_HIGH) ? 10'sd2 : 10'sd1);
            end else begin
                d = d + 10'sd1;
            end
        end else begin
            n_boost_armed  = 1'b1;
            n_auto_started = 1'b0;
            d              = 10'sd0;
            n_mode         = MODE_IDLE;
        end

        // clamp to max first, then min wins
        if (d >= $signed({2'b00, r_duty_max})) begin
            d = $signed({2'b00, r_duty_max});
        end
        if (d <= $signed({2'b00, r_duty_min})) begin
            d = $signed({2'b00, r_duty_min});
        end
        n_duty = d[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty         <= '0;
            r_auto_started <= 1'b0;
            r_boost_armed  <= 1'b1;
        end else if (out_ready && r_s1_valid) begin
            r_duty         <= n_duty;
            r_auto_started <= n_auto_started;
            r_boost_armed  <= n_boost_armed;
        end
    end

    logic [15:0] r_out_current_q8;
    logic [1:0]  r_out_mode;
    logic [5:0]  r_out_boost_limit;

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out_current_q8  <= s1_meas.current_q8;
            r_out_mode        <= n_mode;
            r_out_boost_limit <= s1_meas.boost_limit;
        end
    end

    // the stored duty is the result duty
    assign o_pwm_duty    = r_duty;
    assign o_current_q8  = r_out_current_q8;
    assign o_drive_mode  = r_out_mode;
    assign o_boost_limit = r_out_boost_limit;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import clpr_pkg::*;

    // Own copies of the arithmetic constants, so a wrong package value shows up.
    localparam int CAP_Q8       = 64000;
    localparam int POT_SPAN     = 20;
    localparam int POT_SCALE    = 1023;
    localparam int BOOST_FLOOR  = 15;
    localparam int BOOST_TOP    = 55;
    localparam int DRAIN_CYCLES = 8;       // leave margin after the last result
    localparam int HOLD_CYCLES  = 300;     // long output hold-off to back the block up
    localparam int MAX_CYCLES   = 200000;
    localparam int MAX_REPORTS  = 10;

    // One input item as the block sees it.
    typedef struct packed {
        logic [9:0]  current_sample;
        logic [9:0]  ref_sample;
        logic [9:0]  pot_sample;
        logic [15:0] motor_rpm;
        logic        throttle_pin;
        logic        boost_btn;
    } sample_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  duty;
        logic [15:0] current_q8;
        t_mode       mode;
        logic [5:0]  boost_limit;
    } result_t;

    typedef struct packed {
        logic [15:0] rpm_threshold;
        logic [7:0]  low_limit;
        logic [7:0]  high_limit;
        logic [7:0]  duty_max;
        logic [7:0]  duty_min;
        logic [7:0]  auto_start;
        logic [7:0]  boost_start;
        logic [7:0]  amps_q8;
    } ramp_cfg_t;

    // Button patterns held over a run of items.
    typedef enum int {HOLD_NONE, HOLD_THROTTLE, HOLD_BOOST, HOLD_BOTH} hold_t;

    // Tracks the ramp state, queues the result each accepted item must produce
    // and compares the results coming out of the block against that queue.
    class ramp_scoreboard;
        ramp_cfg_t  cfg;
        logic [7:0] duty;
        logic       auto_started;
        logic       boost_armed;
        result_t    due_outputs[$];
        int         fail_count;

        function new();
            cfg.rpm_threshold = 16'd335;
            cfg.low_limit     = 8'd15;
            cfg.high_limit    = 8'd48;
            cfg.duty_max      = 8'd255;
            cfg.duty_min      = 8'd45;
            cfg.auto_start    = 8'd85;
            cfg.boost_start   = 8'd104;
            cfg.amps_q8       = 8'd79;
            duty          = '0;
            auto_started  = 1'b0;
            boost_armed   = 1'b1;
            fail_count    = 0;
        endfunction

        function result_t next_control_output(sample_t s);
            int      diff;
            int      amps;
            int      limit_a;
            int      pot_q;
            int      d;
            bit      throttle_dn;
            bit      boost_dn;
            bit      over;
            result_t r;
            diff = int'(s.current_sample) - int'(s.ref_sample) - 2;
            amps = (diff > 0) ? diff * int'(cfg.amps_q8) : 0;
            if (amps > CAP_Q8)
                amps = CAP_Q8;
            r.current_q8 = amps[15:0];
            pot_q = int'(s.pot_sample) * POT_SPAN / POT_SCALE;
            r.boost_limit = (pot_q == POT_SPAN) ? 6'(BOOST_TOP) : 6'(BOOST_FLOOR + pot_q);
            if (s.motor_rpm < cfg.rpm_threshold) begin
                r.mode  = MODE_LOW;
                limit_a = int'(cfg.low_limit);
            end else begin
                r.mode  = MODE_HIGH;
                limit_a = int'(cfg.high_limit);
            end
            throttle_dn = !s.throttle_pin;
            boost_dn    = !s.boost_btn;
            d = int'(duty);
            if (throttle_dn || boost_dn) begin
                // first throttle press only preloads when the current is in range
                if (!auto_started && !boost_dn && amps <= limit_a * 256) begin
                    d = int'(cfg.auto_start);
                    auto_started = 1'b1;
                end else if (boost_dn) begin
                    r.mode = MODE_BOOST;
                    if (boost_armed) begin
                        d = int'(cfg.boost_start);
                        boost_armed = 1'b0;
                    end
                end
                if (r.mode == MODE_BOOST)
                    over = amps > int'(r.boost_limit) * 256;
                else
                    over = amps > limit_a * 256;
                if (over)
                    d -= (r.mode == MODE_HIGH) ? 2 : 1;
                else
                    d += 1;
            end else begin
                boost_armed  = 1'b1;
                auto_started = 1'b0;
                d = 0;
                r.mode = MODE_IDLE;
            end
            // max first, then min: min wins when the two cross
            if (d >= int'(cfg.duty_max))
                d = int'(cfg.duty_max);
            if (d <= int'(cfg.duty_min))
                d = int'(cfg.duty_min);
            duty   = d[7:0];
            r.duty = duty;
            return r;
        endfunction

        function void note_sample(sample_t s);
            due_outputs.push_back(next_control_output(s));
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("mismatch: %s", msg);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_outputs.size() == 0) begin
                flag($sformatf("result with nothing expected, duty %0d current %0d",
                               got.duty, got.current_q8));
                return;
            end
            want = due_outputs.pop_front();
            if (got.duty !== want.duty)
                flag($sformatf("pwm_duty expected %0d, got %0d", want.duty, got.duty));
            if (got.current_q8 !== want.current_q8)
                flag($sformatf("current_q8 expected %0d, got %0d",
                               want.current_q8, got.current_q8));
            if (got.mode !== want.mode)
                flag($sformatf("drive_mode expected %0d, got %0d", want.mode, got.mode));
            if (got.boost_limit !== want.boost_limit)
                flag($sformatf("boost_limit expected %0d, got %0d",
                               want.boost_limit, got.boost_limit));
        endfunction
    endclass

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  i_in_valid         = 1'b0;
    logic                  o_in_stall;
    logic [9:0]            i_current_sample   = '0;
    logic [9:0]            i_reference_sample = '0;
    logic [9:0]            i_pot_sample       = '0;
    logic [15:0]           i_motor_rpm        = '0;
    logic                  i_throttle_pin     = 1'b1;
    logic                  i_boost_btn        = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_stall        = 1'b0;
    logic [7:0]            o_pwm_duty;
    logic [15:0]           o_current_q8;
    logic [1:0]            o_drive_mode;
    logic [5:0]            o_boost_limit;
    logic                  i_cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index        = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data         = '0;

    // Flags from the stimulus thread to the output side (written with <= only).
    logic calm_run       = 1'b0;    // no random idling on either side
    logic stall_hold_req = 1'b0;    // ask for one long output hold-off

    // Owned by the output process alone, but for cycle_count, which the hard stop keeps.
    int   stall_hold_left  = 0;
    bit   stall_hold_taken = 1'b0;
    int   cycle_count      = 0;

    ramp_scoreboard sb = new();

    current_limited_pwm_ramp_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_current_sample   (i_current_sample),
        .i_reference_sample (i_reference_sample),
        .i_pot_sample       (i_pot_sample),
        .i_motor_rpm        (i_motor_rpm),
        .i_throttle_pin     (i_throttle_pin),
        .i_boost_btn        (i_boost_btn),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_pwm_duty         (o_pwm_duty),
        .o_current_q8       (o_current_q8),
        .o_drive_mode       (o_drive_mode),
        .o_boost_limit      (o_boost_limit),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Hard stop in case the block hangs or drops items.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output side: random stalls, one long hold-off on request, and the check
    // of every result taken. Ports are read at the edge, before any update.
    always @(posedge i_clk) begin
        result_t got;
        if (stall_hold_req && !stall_hold_taken) begin
            stall_hold_left  = HOLD_CYCLES;
            stall_hold_taken = 1'b1;
        end
        if (stall_hold_left > 0) begin
            i_out_stall <= 1'b1;
            stall_hold_left--;
        end else begin
            i_out_stall <= !calm_run && ($urandom_range(99) < 7);
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got.duty        = o_pwm_duty;
            got.current_q8  = o_current_q8;
            got.mode        = t_mode'(o_drive_mode);
            got.boost_limit = o_boost_limit;
            sb.check_result(got);
        end
    end

    // Offer one item, with optional idle cycles first. Valid stays high after
    // the handshake so back-to-back items never drop it within a time step.
    task automatic send_item(sample_t s);
        while (!calm_run && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_current_sample   <= s.current_sample;
        i_reference_sample <= s.ref_sample;
        i_pot_sample       <= s.pot_sample;
        i_motor_rpm        <= s.motor_rpm;
        i_throttle_pin     <= s.throttle_pin;
        i_boost_btn        <= s.boost_btn;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_sample(s);
    endtask

    task automatic send_fields(int cur, int refs, int pot, int rpm, bit thr, bit bst);
        sample_t s;
        s.current_sample = 10'(cur);
        s.ref_sample     = 10'(refs);
        s.pot_sample     = 10'(pot);
        s.motor_rpm      = 16'(rpm);
        s.throttle_pin   = thr;
        s.boost_btn      = bst;
        send_item(s);
    endtask

    // Stop offering, let every expected result come back, then some margin.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.due_outputs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic apply_config(ramp_cfg_t c);
        write_reg(CFG_RPM_THRESHOLD,    c.rpm_threshold);
        write_reg(CFG_LOW_LIMIT,        16'(c.low_limit));
        write_reg(CFG_HIGH_LIMIT,       16'(c.high_limit));
        write_reg(CFG_DUTY_MAX,         16'(c.duty_max));
        write_reg(CFG_DUTY_MIN,         16'(c.duty_min));
        write_reg(CFG_AUTO_START_DUTY,  16'(c.auto_start));
        write_reg(CFG_BOOST_START_DUTY, 16'(c.boost_start));
        write_reg(CFG_AMPS_PER_BIT_Q8,  16'(c.amps_q8));
        i_cfg_we <= 1'b0;
        sb.cfg = c;
    endtask

    function automatic ramp_cfg_t random_cfg();
        ramp_cfg_t c;
        c.rpm_threshold = 16'($urandom_range(65535));
        c.low_limit     = 8'($urandom_range(250));
        c.high_limit    = 8'($urandom_range(250));
        c.duty_min      = 8'($urandom_range(120));
        c.duty_max      = 8'($urandom_range(255, 130));
        c.auto_start    = 8'($urandom_range(255));
        c.boost_start   = 8'($urandom_range(255));
        c.amps_q8       = 8'($urandom_range(255, 1));
        return c;
    endfunction

    // Random item for the given button pattern. Current and rpm are steered
    // toward the limit and threshold edges part of the time.
    function automatic sample_t random_sample(hold_t pat);
        sample_t s;
        int      lim_a;
        int      diff;
        int      ref_i;
        int      cur_i;
        int      rpm_i;
        s.throttle_pin = !(pat == HOLD_THROTTLE || pat == HOLD_BOTH);
        s.boost_btn    = !(pat == HOLD_BOOST || pat == HOLD_BOTH);
        if ($urandom_range(99) < 8) begin
            // button noise inside a sequence
            s.throttle_pin = 1'($urandom_range(1));
            s.boost_btn    = 1'($urandom_range(1));
        end
        case ($urandom_range(9))
            0:       s.pot_sample = 10'd0;
            1:       s.pot_sample = 10'd1023;
            2:       s.pot_sample = 10'd1022;
            default: s.pot_sample = 10'($urandom_range(1023));
        endcase
        case ($urandom_range(9))
            0, 1, 2: begin
                rpm_i = int'(sb.cfg.rpm_threshold) + int'($urandom_range(2)) - 1;
                if (rpm_i < 0)
                    rpm_i = 0;
                if (rpm_i > 65535)
                    rpm_i = 65535;
                s.motor_rpm = 16'(rpm_i);
            end
            3:       s.motor_rpm = 16'd0;
            4:       s.motor_rpm = 16'hFFFF;
            default: s.motor_rpm = 16'($urandom_range(65535));
        endcase
        ref_i = int'($urandom_range(1023));
        if ($urandom_range(99) < 45 && sb.cfg.amps_q8 != 0) begin
            case ($urandom_range(2))
                0:       lim_a = int'(sb.cfg.low_limit);
                1:       lim_a = int'(sb.cfg.high_limit);
                default: lim_a = int'($urandom_range(55, 15));
            endcase
            diff  = lim_a * 256 / int'(sb.cfg.amps_q8) + int'($urandom_range(4)) - 2;
            cur_i = ref_i + 2 + diff;
            if (cur_i > 1023) begin
                ref_i -= cur_i - 1023;
                cur_i  = 1023;
            end
            if (ref_i < 0)
                ref_i = 0;
            if (cur_i < 0)
                cur_i = 0;
        end else if ($urandom_range(99) < 20) begin
            // right around the sensor offset
            cur_i = ref_i + int'($urandom_range(6));
            if (cur_i > 1023)
                cur_i = 1023;
        end else begin
            cur_i = int'($urandom_range(1023));
        end
        s.current_sample = 10'(cur_i);
        s.ref_sample     = 10'(ref_i);
        return s;
    endfunction

    // Mostly held button sequences with random content, short releases between.
    task automatic run_random(int count);
        hold_t pat;
        int    run_len;
        int    roll;
        pat     = HOLD_NONE;
        run_len = 0;
        for (int k = 0; k < count; k++) begin
            if (run_len == 0) begin
                roll = int'($urandom_range(99));
                if (roll < 20)
                    pat = HOLD_NONE;
                else if (roll < 55)
                    pat = HOLD_THROTTLE;
                else if (roll < 80)
                    pat = HOLD_BOOST;
                else
                    pat = HOLD_BOTH;
                run_len = (pat == HOLD_NONE) ? int'($urandom_range(3, 1))
                                             : int'($urandom_range(24, 2));
            end
            run_len--;
            send_item(random_sample(pat));
        end
    endtask

    initial begin
        ramp_cfg_t c;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items on the reset settings.
        //          cur   ref   pot   rpm    thr bst
        send_fields(0,    1023, 0,    0,     1, 1);   // idle, negative difference
        send_fields(500,  500,  512,  100,   0, 1);   // first throttle press preloads
        send_fields(1023, 0,    0,    334,   0, 1);   // over the low limit, capped current
        send_fields(1023, 0,    0,    335,   0, 1);   // at threshold: high mode, down by 2
        send_fields(502,  500,  0,    65535, 0, 1);   // high mode within limit
        send_fields(503,  500,  0,    10,    0, 1);   // one bit above the offset
        send_fields(0,    0,    0,    0,     1, 1);   // release
        send_fields(1023, 0,    0,    0,     0, 1);   // first press over limit: no preload
        send_fields(200,  200,  0,    0,     0, 1);   // now in range: preload
        send_fields(600,  400,  1023, 0,     0, 0);   // both held: boost, full-scale pot
        send_fields(600,  400,  0,    0,     0, 0);   // boost limit at its floor
        send_fields(1023, 1023, 1022, 0,     1, 0);   // boost alone, pot just below full
        send_fields(0,    0,    0,    0,     1, 1);   // release re-arms boost
        send_fields(0,    0,    972,  0,     1, 0);   // boost press preloads
        send_fields(302,  300,  972,  0,     1, 0);   // difference exactly the offset
        send_fields(1023, 1023, 0,    65535, 1, 1);   // release at top rpm
        send_fields(1023, 0,    1023, 65535, 0, 1);   // throttle, everything at full scale
        send_fields(0,    0,    0,    0,     1, 1);
        settle();

        // Exact-limit cases: 128/256 A per bit puts 30 bits right on 15 A.
        c = '{rpm_threshold: 16'd1000, low_limit: 8'd15, high_limit: 8'd250,
              duty_max: 8'd255, duty_min: 8'd0, auto_start: 8'd255,
              boost_start: 8'd0, amps_q8: 8'd128};
        apply_config(c);
        send_fields(0,    0,    0,    0,     1, 1);   // idle with a zero floor
        send_fields(132,  100,  0,    0,     0, 1);   // at limit: preload, step past max
        send_fields(133,  100,  0,    0,     0, 1);   // one bit over
        send_fields(1023, 0,    0,    1000,  0, 1);   // capped current equals high limit
        send_fields(133,  100,  0,    0,     1, 0);   // boost preload of zero, step below
        send_fields(132,  100,  0,    0,     1, 0);   // boost at its limit
        send_fields(0,    0,    0,    0,     1, 1);
        settle();

        // Reset values written back explicitly.
        c = '{rpm_threshold: 16'd335, low_limit: 8'd15, high_limit: 8'd48,
              duty_max: 8'd255, duty_min: 8'd45, auto_start: 8'd85,
              boost_start: 8'd104, amps_q8: 8'd79};
        apply_config(c);
        run_random(80);
        settle();

        // Everything at zero: no current, duty pinned at zero.
        c = '0;
        apply_config(c);
        run_random(60);
        settle();

        // Everything at the top of its range.
        c = '{rpm_threshold: 16'hFFFF, low_limit: 8'd250, high_limit: 8'd250,
              duty_max: 8'd255, duty_min: 8'd255, auto_start: 8'd255,
              boost_start: 8'd255, amps_q8: 8'd255};
        apply_config(c);
        run_random(60);
        settle();

        // Crossed clamps: the floor wins.
        c = random_cfg();
        c.duty_max = 8'd100;
        c.duty_min = 8'd200;
        apply_config(c);
        run_random(60);
        settle();

        // A stretch with no idling on either side.
        apply_config(random_cfg());
        calm_run <= 1'b1;
        run_random(90);
        settle();
        calm_run <= 1'b0;

        // Long output hold-off while items keep coming: the pipeline fills
        // and the input side has to stall.
        apply_config(random_cfg());
        run_random(15);
        stall_hold_req <= 1'b1;
        run_random(75);
        settle();

        apply_config(random_cfg());
        run_random(110);
        settle();

        if (sb.fail_count == 0 && sb.due_outputs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
